/* hdl/selective_repeat_receiver_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the selective-repeat receiver
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_UNIT_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srr: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srr: next-cycle check failed");

// Condition must never be true.
`define SRR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("srr: forbidden condition seen");

`endif

/* hdl/srr_pkg.sv */
// ---------------------------------------------------------------------------
// srr_pkg
// Shared types and constants of the selective-repeat receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package srr_pkg;

  localparam int unsigned WINDOW_DEF      = 8;
  localparam int unsigned SEQ_SPACE_DEF   = 16;
  localparam int unsigned MAX_SENDERS_DEF = 16;

  localparam int unsigned SEQ_W     = 4;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECEIVER_ID,
    REG_SENDER_COUNT
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_ACK,
    KIND_NAK,
    KIND_DLV
  } kind_e;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq_number;
    logic [ID_W-1:0]   source_id;
    logic [ID_W-1:0]   dest_id;
    logic              crc_ok;
    logic [DATA_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [ID_W-1:0]   peer_id;
    logic [SEQ_W-1:0]  reply_seq;
    logic [DATA_W-1:0] data_out;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_REPLY,
    ST_READ,
    ST_DELIVER
  } state_e;

  typedef struct packed {
    logic capture;  // latch the incoming request
    logic eval;     // latch window lookup results
    logic reply;    // load ACK or NAK into the output register
    logic store;    // write payload and set the received flag
    logic deliver;  // load a delivery and slide the window by one
  } ctrl_cmd_t;

  typedef struct packed {
    logic drop;
    logic crc_ok;
    logic in_win;
    logic off_zero;
    logic out_free;
    logic more;
  } ctrl_status_t;

endpackage

`default_nettype wire

/* hdl/srr_ctrl.sv */
// ---------------------------------------------------------------------------
// srr_ctrl
// Sequencer of the receiver: evaluate, answer, then drain the in-order run.
// ---------------------------------------------------------------------------
`default_nettype none

module srr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  srr_pkg::ctrl_status_t status_i,
  output srr_pkg::ctrl_cmd_t   cmd_o
);
  import srr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ST_REPLY;
      end
      ST_REPLY: begin
        if (status_i.drop) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.reply = 1'b1;
          cmd_o.store = status_i.crc_ok && status_i.in_win;
          // A frame with a good CRC that lands on the left edge always starts a delivery run.
          if (status_i.crc_ok && status_i.in_win && status_i.off_zero) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (status_i.out_free) begin
          cmd_o.deliver = 1'b1;
          state_d       = status_i.more ? ST_DELIVER : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/srr_datapath.sv */
// ---------------------------------------------------------------------------
// srr_datapath
// Window state, payload buffer and output register of the receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module srr_datapath #(
  parameter int unsigned WINDOW      = srr_pkg::WINDOW_DEF,
  parameter int unsigned SEQ_SPACE   = srr_pkg::SEQ_SPACE_DEF,
  parameter int unsigned MAX_SENDERS = srr_pkg::MAX_SENDERS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  srr_pkg::reg_idx_e         cfg_idx_i,
  input  logic [srr_pkg::CFG_W-1:0] cfg_data_i,
  input  srr_pkg::in_item_t         in_data_i,
  input  srr_pkg::ctrl_cmd_t        cmd_i,
  output srr_pkg::ctrl_status_t     status_o,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output srr_pkg::out_item_t        out_data_o
);
  import srr_pkg::*;

  localparam int unsigned WinW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SeqW  = $clog2(SEQ_SPACE);
  localparam int unsigned SndW  = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;
  localparam int unsigned Depth = MAX_SENDERS * WINDOW;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CmpW  = 10;
  localparam int unsigned SeqN  = 1 << SEQ_W;
  localparam logic [AddrW-1:0] WinA = AddrW'(WINDOW);

  // Configuration registers.
  logic [ID_W-1:0]  rx_id_q;
  logic [CNT_W-1:0] snd_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_id_q   <= '0;
      snd_cnt_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RECEIVER_ID:  rx_id_q   <= cfg_data_i;
        REG_SENDER_COUNT: snd_cnt_q <= cfg_data_i[CNT_W-1:0];
      endcase
    end
  end

  // Sequence number reduced into the sequence space.
  logic [SeqW-1:0] seq_mod [SeqN];
  for (genvar v = 0; v < SeqN; v++) begin : g_seq_mod
    localparam int unsigned Rem = v % SEQ_SPACE;
    assign seq_mod[v] = SeqW'(Rem);
  end

  in_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
  end

  // Per-sender window state. The base pointer locates the left edge slot
  // inside the ring of WINDOW physical slots.
  logic [WINDOW-1:0] flags_q [MAX_SENDERS];
  logic [WinW-1:0]   base_q  [MAX_SENDERS];
  logic [SeqW-1:0]   edge_q  [MAX_SENDERS];

  // Lookup for the captured request.
  logic [SndW-1:0] sidx;
  logic [SeqW-1:0] edge_cur;
  logic [WinW-1:0] base_cur;
  logic [SeqW:0]   off_sum;
  logic [SeqW-1:0] off;
  logic [WinW-1:0] off_w;
  logic [WinW:0]   phys_sum;
  logic [WinW-1:0] phys;
  logic            in_win;
  logic            src_ok;
  logic            drop;

  always_comb begin
    sidx     = item_q.source_id[SndW-1:0];
    edge_cur = edge_q[sidx];
    base_cur = base_q[sidx];
    off_sum  = (SeqW+1)'(seq_mod[item_q.seq_number]) + (SeqW+1)'(SEQ_SPACE)
             - (SeqW+1)'(edge_cur);
    off      = (off_sum >= (SeqW+1)'(SEQ_SPACE)) ?
               SeqW'(off_sum - (SeqW+1)'(SEQ_SPACE)) : SeqW'(off_sum);
    in_win   = CmpW'(off) < CmpW'(WINDOW);
    off_w    = WinW'(off);
    phys_sum = (WinW+1)'(base_cur) + (WinW+1)'(off_w);
    phys     = (phys_sum >= (WinW+1)'(WINDOW)) ?
               WinW'(phys_sum - (WinW+1)'(WINDOW)) : WinW'(phys_sum);
    src_ok   = (item_q.source_id < ID_W'(snd_cnt_q)) &&
               ((ID_W+1)'(item_q.source_id) < (ID_W+1)'(MAX_SENDERS));
    drop     = (item_q.dest_id != rx_id_q) || !src_ok;
  end

  logic            drop_q;
  logic            inwin_q;
  logic            offz_q;
  logic [SndW-1:0] sidx_q;
  logic [WinW-1:0] wr_p_q;
  logic [WinW-1:0] cur_p_q;
  logic [SeqW-1:0] cur_le_q;
  logic [WinW-1:0] p_next;
  logic [SeqW-1:0] le_next;

  assign p_next  = (cur_p_q == WinW'(WINDOW - 1)) ? '0 : cur_p_q + WinW'(1);
  assign le_next = (cur_le_q == SeqW'(SEQ_SPACE - 1)) ? '0 : cur_le_q + SeqW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      drop_q   <= drop;
      inwin_q  <= in_win;
      offz_q   <= (off == '0);
      sidx_q   <= sidx;
      wr_p_q   <= phys;
      cur_p_q  <= base_cur;
      cur_le_q <= edge_cur;
    end else if (cmd_i.deliver) begin
      cur_p_q  <= p_next;
      cur_le_q <= le_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MAX_SENDERS; s++) begin
        flags_q[s] <= '0;
        base_q[s]  <= '0;
        edge_q[s]  <= '0;
      end
    end else begin
      if (cmd_i.store) begin
        flags_q[sidx_q][wr_p_q] <= 1'b1;
      end
      if (cmd_i.deliver) begin
        flags_q[sidx_q][cur_p_q] <= 1'b0;
        base_q[sidx_q]           <= p_next;
        edge_q[sidx_q]           <= le_next;
      end
    end
  end

  logic [WINDOW-1:0] cur_flags;
  logic              more;

  assign cur_flags = flags_q[sidx_q];
  // With a one-slot window the next slot is the one being emptied.
  assign more      = (p_next != cur_p_q) && cur_flags[p_next];

  // Payload buffer, one row of WINDOW words per sender.
  logic [DATA_W-1:0] payload_mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;
  logic [AddrW-1:0]  wr_addr;
  logic [AddrW-1:0]  rd_addr;

  assign wr_addr = AddrW'(sidx_q) * WinA + AddrW'(wr_p_q);
  // Prefetch the next slot while the current one is handed out.
  assign rd_addr = AddrW'(sidx_q) * WinA + AddrW'(cmd_i.deliver ? p_next : cur_p_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      payload_mem_q[wr_addr] <= item_q.payload;
    end
    rdata_q <= payload_mem_q[rd_addr];
  end

  // Output register.
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t reply_item;
  out_item_t dlv_item;
  logic      out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    reply_item.kind      = item_q.crc_ok ? KIND_ACK : KIND_NAK;
    reply_item.peer_id   = item_q.source_id;
    reply_item.reply_seq = item_q.seq_number;
    reply_item.data_out  = '0;
    reply_item.last      = !item_q.crc_ok || !(inwin_q && offz_q);

    dlv_item.kind        = KIND_DLV;
    dlv_item.peer_id     = item_q.source_id;
    dlv_item.reply_seq   = SEQ_W'(cur_le_q);
    dlv_item.data_out    = rdata_q;
    dlv_item.last        = !more;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.reply || cmd_i.deliver) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.reply) begin
      out_q <= reply_item;
    end else if (cmd_i.deliver) begin
      out_q <= dlv_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.drop     = drop_q;
  assign status_o.crc_ok   = item_q.crc_ok;
  assign status_o.in_win   = inwin_q;
  assign status_o.off_zero = offz_q;
  assign status_o.out_free = out_free;
  assign status_o.more     = more;

endmodule

`default_nettype wire

/* hdl/selective_repeat_receiver_unit.sv */
// ---------------------------------------------------------------------------
// selective_repeat_receiver_unit
// Selective-repeat receiver: per-sender windows, ACK/NAK and in-order delivery.
// Each accepted request is evaluated; unless dropped, its ACK or NAK is then loaded into
// the output register once that is free. No new request is taken until the reply and any
// run of up to WINDOW deliveries ends; they leave the buffer one per cycle while not stalled.
// Reset: all windows empty with left edge 0, receiver_id 0, sender_count 1;
// the payload buffer is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
`include "selective_repeat_receiver_unit_defines.svh"

module selective_repeat_receiver_unit #(
  parameter int unsigned WINDOW      = srr_pkg::WINDOW_DEF,
  parameter int unsigned SEQ_SPACE   = srr_pkg::SEQ_SPACE_DEF,
  parameter int unsigned MAX_SENDERS = srr_pkg::MAX_SENDERS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  srr_pkg::reg_idx_e         cfg_idx_i,
  input  logic [srr_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  srr_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output srr_pkg::out_item_t        out_data_o
);
  import srr_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  srr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srr_datapath #(
    .WINDOW      (WINDOW),
    .SEQ_SPACE   (SEQ_SPACE),
    .MAX_SENDERS (MAX_SENDERS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // A request is evaluated before the next one can be taken.
  `SRR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // Acknowledgements never carry payload data.
  `SRR_ASSERT_IMPL(a_reply_zero_data, out_valid_o && out_data_o.kind != KIND_DLV, out_data_o.data_out == '0)
  // The output register is loaded from one source at a time.
  `SRR_ASSERT_NEVER(a_single_load, cmd.reply && cmd.deliver)

endmodule

`default_nettype wire
